/* rtl/core/moving_average_rms_filter_top_assert.svh */
// Assertion macros shared by the filter modules.
`ifndef MOVING_AVERAGE_RMS_FILTER_TOP_ASSERT_SVH
`define MOVING_AVERAGE_RMS_FILTER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/core/maf_pkg.sv */
`default_nettype none
package maf_pkg;
	localparam int MaxWindow = 1024;
	localparam int PtrW = $clog2(MaxWindow);
	localparam int CntW = PtrW + 1;
	localparam int SampleW = 16;
	localparam int TotalW = 41;
	localparam int SqrtW = 20;
	localparam logic [CntW-1:0] WindowReset = CntW'(100);
	localparam logic [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
	localparam logic [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

	// Register indexes.
	localparam logic [0:0] RegWindow = 1'b0;
	localparam logic [0:0] RegMode = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic read_old;
		logic sub_old;
		logic add_new;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic finish;
	} maf_cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic full;
		logic rms;
	} maf_sts_t;
endpackage
`default_nettype wire

/* rtl/core/maf_stream_if.sv */
`default_nettype none
interface maf_stream_if;
	import maf_pkg::*;
	logic valid;
	logic ready;
	logic signed [SampleW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/maf_datapath.sv */
`default_nettype none
`include "moving_average_rms_filter_top_assert.svh"
module maf_datapath
	import maf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire maf_cmd_t                  cmd,
	input  wire logic [CntW-1:0]           window_length,
	input  wire logic                      rms_mode,
	input  wire logic [SampleW-1:0]        sample,
	output maf_sts_t                       sts,
	output logic [SampleW-1:0]             result
);
	logic [SampleW-1:0] ring [MaxWindow];
	logic [SampleW-1:0] old_q, new_q;
	logic [TotalW-1:0] total_q;
	logic [CntW-1:0] held_q;
	logic [PtrW-1:0] wpos_q;
	logic [CntW-1:0] win;
	logic [PtrW-1:0] old_addr;
	logic signed [2*SampleW-1:0] old_sq, new_sq;
	logic [TotalW-1:0] old_c, new_c;
	// Divider: magnitude quotient, restoring, one bit a step.
	logic [TotalW-1:0] quo_q;
	logic [CntW-1:0] rem_q;
	logic neg_q;
	logic [CntW:0] rem_try;
	logic [CntW:0] rem_sh;
	// Square root of the quotient, one result bit a step.
	logic [SqrtW-1:0] root_q;
	logic [4:0] sidx_q;
	logic [SqrtW+1:0] trial;
	logic [2*SqrtW+3:0] trial_sq;
	logic [2*SqrtW+3:0] rem_s;
	logic [SampleW-1:0] mean_sat;

	// Clamped window.
	always_comb begin
		win = window_length;
		if (win == '0) win = CntW'(1);
		if (win > CntW'(MaxWindow)) win = CntW'(MaxWindow);
	end
	assign old_addr = wpos_q - win[PtrW-1:0];
	assign sts = '{full: (held_q >= win), rms: rms_mode};

	// Squares of the oldest and the newest sample.
	assign old_sq = $signed(old_q) * $signed(old_q);
	assign new_sq = $signed(new_q) * $signed(new_q);

	// Contributions: sign-extended sample or its square.
	always_comb begin
		if (rms_mode) begin
			old_c = TotalW'(old_sq);
			new_c = TotalW'(new_sq);
		end else begin
			old_c = TotalW'($signed(old_q));
			new_c = TotalW'($signed(new_q));
		end
	end

	// Sample ring.
	always_ff @(posedge clk) begin
		if (cmd.load) ring[wpos_q] <= sample;
		if (cmd.read_old) old_q <= ring[old_addr];
		if (cmd.load) new_q <= sample;
	end

	assign rem_sh = {rem_q, quo_q[TotalW-1]};
	assign rem_try = rem_sh - {1'b0, held_q};
	assign trial = {2'b0, root_q} | (SqrtW+2)'((SqrtW+1)'(1) << sidx_q);
	assign trial_sq = trial * trial;
	assign rem_s = (2*SqrtW+4)'(quo_q);

	// History, divider and square root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			held_q <= '0;
			wpos_q <= '0;
		end else begin
			if (cmd.clear) begin
				total_q <= '0;
				held_q <= '0;
				wpos_q <= '0;
			end else begin
				if (cmd.load) begin
					wpos_q <= wpos_q + PtrW'(1);
					if (!sts.full) held_q <= held_q + CntW'(1);
				end
				// The new term goes in, and the oldest comes out once the window is full.
				if (cmd.sub_old) total_q <= total_q - old_c + new_c;
				else if (cmd.add_new) total_q <= total_q + new_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= !rms_mode && total_q[TotalW-1];
			quo_q <= (!rms_mode && total_q[TotalW-1]) ? -total_q : total_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!rem_try[CntW]) begin
				rem_q <= rem_try[CntW-1:0];
				quo_q <= {quo_q[TotalW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CntW-1:0];
				quo_q <= {quo_q[TotalW-2:0], 1'b0};
			end
		end
		if (cmd.sqrt_start) begin
			root_q <= '0;
			sidx_q <= 5'(SqrtW-1);
		end else if (cmd.sqrt_step) begin
			if (trial_sq <= rem_s) root_q <= trial[SqrtW-1:0];
			sidx_q <= sidx_q - 5'd1;
		end
		if (cmd.finish) begin
			if (rms_mode) begin
				result <= (root_q > SqrtW'(SampleMax)) ? SampleMax : root_q[SampleW-1:0];
			end else begin
				result <= mean_sat;
			end
		end
	end

	// Signed mean with saturation.
	always_comb begin
		if (neg_q) begin
			mean_sat = (quo_q > TotalW'(32768)) ? SampleMin
				: SampleW'(-quo_q);
		end else begin
			mean_sat = (quo_q > TotalW'(SampleMax)) ? SampleMax : quo_q[SampleW-1:0];
		end
	end

	`MAF_ASSERT_NXT(a_held_bound, clk, arst_n, 1'b1, held_q <= CntW'(MaxWindow))
	`MAF_ASSERT_NXT(a_clear, clk, arst_n, cmd.clear, total_q == '0 && held_q == '0)
	`MAF_ASSERT_IMP(a_one_op, clk, arst_n, 1'b1, !(cmd.div_step && cmd.sqrt_step))
endmodule
`default_nettype wire

/* rtl/core/maf_ctrl.sv */
`default_nettype none
`include "moving_average_rms_filter_top_assert.svh"
module maf_ctrl
	import maf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_write,
	input  wire logic     in_beat,
	input  wire logic     out_ready,
	input  wire maf_sts_t sts,
	output maf_cmd_t      cmd,
	output logic          in_ready,
	output logic          out_valid
);
	typedef enum logic [2:0] {S_IDLE, S_READ, S_SUB, S_ADD, S_DIV, S_SQRT, S_FIN, S_OUT}
		state_t;
	state_t state_q;
	logic [5:0] cnt_q;
	logic full_q;

	assign in_ready = (state_q == S_IDLE) && !cfg_write;

	// The total is updated in S_SUB, so S_ADD loads the divider with the new total.
	always_comb begin
		cmd = '0;
		cmd.clear = cfg_write;
		cmd.load = in_beat;
		cmd.read_old = in_beat;
		cmd.sub_old = (state_q == S_SUB) && full_q;
		cmd.add_new = (state_q == S_SUB);
		cmd.div_start = (state_q == S_ADD);
		cmd.div_step = (state_q == S_DIV);
		cmd.sqrt_start = (state_q == S_DIV) && cnt_q == '0 && sts.rms;
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.finish = (state_q == S_FIN);
	end

	// Sequencer: the full flag is sampled at the input beat, before held count moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			full_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_beat) begin
					state_q <= S_SUB;
					full_q <= sts.full;
				end
				S_READ: state_q <= S_SUB;
				S_SUB: state_q <= S_ADD;
				S_ADD: begin
					state_q <= S_DIV;
					cnt_q <= 6'(TotalW-1);
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= sts.rms ? S_SQRT : S_FIN;
						cnt_q <= 6'(SqrtW-1);
					end else cnt_q <= cnt_q - 6'd1;
				end
				S_SQRT: begin
					if (cnt_q == '0) state_q <= S_FIN;
					else cnt_q <= cnt_q - 6'd1;
				end
				S_FIN: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					state_q <= S_IDLE;
					out_valid <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MAF_ASSERT_IMP(a_valid_state, clk, arst_n, out_valid, state_q == S_OUT)
	`MAF_ASSERT_NXT(a_accept, clk, arst_n, in_beat, state_q == S_SUB)
	`MAF_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid)
endmodule
`default_nettype wire

/* rtl/core/moving_average_rms_filter_top.sv */
// A new sample is accepted only while idle with no register write pending, so the
// previous result must have been taken first; the processing time is set by the
// bit-serial divider (41 steps) and square root (20 steps).
// Reset (arst_n low, asynchronous): history empty, window 100, mean mode.
// Any register write clears the history; the ring itself needs no clearing.
`default_nettype none
`include "moving_average_rms_filter_top_assert.svh"
module moving_average_rms_filter_top
	import maf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	maf_stream_if.sink       in_s,
	maf_stream_if.source     out_s,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [CntW-1:0] win_q;
	logic mode_q;
	logic wr, cfg_hit, in_beat;
	maf_cmd_t cmd;
	maf_sts_t sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg_hit = wr && (paddr[1:0] == 2'b00) && (paddr[2] == RegWindow || paddr[2] == RegMode);
	assign in_beat = in_s.valid && in_s.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WindowReset;
			mode_q <= 1'b0;
		end else if (cfg_hit) begin
			unique case (paddr[2])
				RegWindow: win_q <= pwdata[CntW-1:0];
				RegMode: mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == RegWindow) prdata = 32'(win_q);
			else prdata = 32'(mode_q);
		end
	end

	maf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_hit), .in_beat(in_beat),
		.out_ready(out_s.ready), .sts(sts), .cmd(cmd), .in_ready(in_s.ready),
		.out_valid(out_s.valid)
	);

	maf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .window_length(win_q), .rms_mode(mode_q),
		.sample(in_s.data), .sts(sts), .result(out_s.data)
	);

	`MAF_ASSERT_IMP(a_no_cfg_in, clk, arst_n, cfg_hit, !in_s.ready)
	`MAF_ASSERT_NXT(a_out_hold, clk, arst_n, out_s.valid && !out_s.ready, out_s.valid)
	`MAF_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
endmodule
`default_nettype wire
